FILE: sv/ctvi_pkg.sv
// Shared types and constants for the vertical candela table interpolator.
// No dependencies.
package ctvi_pkg;

   localparam int ANGLE_W     = 14;
   localparam int INDEX_W     = 10;
   localparam int CANDELA_W   = 20;
   localparam int SUM_W       = 30;
   localparam int INTENSITY_W = 28;
   localparam int CSR_W       = 11;
   localparam int DVD_W       = 38;   // sum << 8 or angle difference << 16
   localparam int DVS_W       = 16;
   localparam int FRAC_W      = 16;

   typedef enum logic [1:0] {
      OP_WRITE_ANGLE = 2'd0,
      OP_ADD_CANDELA = 2'd1,
      OP_QUERY       = 2'd2,
      OP_CLEAR_SUMS  = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_NUM_VERT = 1'b0,
      CSR_NUM_HORZ = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                 operation;
      logic [INDEX_W-1:0]     index;
      logic [ANGLE_W-1:0]     angle;
      logic [CANDELA_W-1:0]   candela;
   } req_type;

   typedef struct packed {
      logic [INTENSITY_W-1:0] intensity;
      logic                   found;
   } rsp_type;

   typedef enum logic [1:0] {
      COL_SEL_INDEX = 2'd0,
      COL_SEL_LOW   = 2'd1,
      COL_SEL_HIGH  = 2'd2
   } col_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_SCAN,
      ST_RD0, ST_DIV0_GO, ST_DIV0, ST_RD1, ST_DIV1_GO, ST_DIV1,
      ST_DIVF, ST_MUL, ST_FIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        ang_wr;
      logic        add_wr;
      logic        clr_init;
      logic        clr_wr;
      logic        scan_init;
      logic        scan;
      logic        sel_zero;
      col_sel_type col_sel;
      logic        div_start;
      logic        div_frac;
      logic        store_a0;
      logic        store_a1;
      logic        store_f;
      logic        mul;
      logic        fin;
      logic        single_res;
      logic        zero_res;
      logic        rsp_valid;
   } cmd_type;

   typedef struct packed {
      logic nv_zero;
      logic nh_zero;
      logic nv_one;
      logic scan_hit;
      logic scan_end;
      logic div_done;
      logic clr_last;
   } status_type;

endpackage

FILE: sv/ctvi_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ctvi_pkg for operand widths.
module ctvi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ctvi_pkg::DVD_W-1:0] dividend,
   input  logic [ctvi_pkg::DVS_W-1:0] divisor,
   output logic                       done,
   output logic [ctvi_pkg::DVD_W-1:0] quotient
);
   import ctvi_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = '0;
         run_in = 1'b1;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         // shift the dividend out as the quotient shifts in
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/ctvi_dp.sv
// Datapath: angle and column-sum memories, scan counter, divider, interpolation.
// Depends on ctvi_pkg and ctvi_div.
module ctvi_dp #(
   parameter int MAX_VERT = 1024,
   parameter int MAX_HORZ = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctvi_pkg::cmd_type          cmd,
   output ctvi_pkg::status_type       status,
   input  ctvi_pkg::req_type          req_data,
   input  logic                       csr_wr,
   input  ctvi_pkg::csr_index_type    csr_index,
   input  logic [ctvi_pkg::CSR_W-1:0] csr_data,
   output ctvi_pkg::rsp_type          rsp_data
);
   import ctvi_pkg::*;

   localparam int AW = (MAX_VERT > 1) ? $clog2(MAX_VERT) : 1;
   localparam int CW = $clog2(MAX_VERT + 1);

   logic [ANGLE_W-1:0] angle_mem [MAX_VERT];
   logic [SUM_W-1:0]   col_mem   [MAX_VERT];

   logic [CSR_W-1:0]       num_vert_ff, num_horz_ff;
   logic [CSR_W-1:0]       nv, nh;
   req_type                req_ff;
   logic [ANGLE_W-1:0]     ang_q_ff, prev_ff, lo_ff, hi_ff;
   logic [SUM_W-1:0]       col_q_ff;
   logic [CW-1:0]          cnt_ff;
   logic [AW-1:0]          clr_ff, sel_ff;
   logic [INTENSITY_W-1:0] a0_ff, a1_ff;
   logic [FRAC_W-1:0]      f_ff;
   logic signed [INTENSITY_W+FRAC_W+1:0] prod_ff;
   rsp_type                rsp_ff;

   logic [AW-1:0]          req_addr, idx_addr, col_addr;
   logic                   req_ok, idx_ok;
   logic [SUM_W:0]         sum_ext;
   logic [SUM_W-1:0]       sum_sat;
   logic                   hit;
   logic [DVD_W-1:0]       dvd;
   logic [DVS_W-1:0]       dvs;
   logic                   div_done;
   logic [DVD_W-1:0]       quo;
   logic [INTENSITY_W-1:0] avg;
   logic signed [INTENSITY_W:0]          delta;
   logic signed [INTENSITY_W+FRAC_W+1:0] prod_in;
   logic [INTENSITY_W+FRAC_W+1:0]        interp;

   always_comb begin
      nv = (32'(num_vert_ff) > MAX_VERT) ? CSR_W'(MAX_VERT) : num_vert_ff;
      nh = (32'(num_horz_ff) > MAX_HORZ) ? CSR_W'(MAX_HORZ) : num_horz_ff;
      req_addr = AW'(req_data.index);
      req_ok   = 32'(req_data.index) < MAX_VERT;
      idx_addr = AW'(req_ff.index);
      idx_ok   = 32'(req_ff.index) < MAX_VERT;
      sum_ext  = {1'b0, col_q_ff} + (SUM_W + 1)'(req_ff.candela);
      sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      // the lower bracket edge is the previous word, the upper one the word just read
      hit      = (32'(cnt_ff) >= 2) && (req_ff.angle >= prev_ff) && (req_ff.angle < ang_q_ff);
      unique case (cmd.col_sel)
         COL_SEL_LOW:  col_addr = sel_ff;
         COL_SEL_HIGH: col_addr = sel_ff + 1'b1;
         default:      col_addr = idx_addr;
      endcase
      if (cmd.div_frac) begin
         dvd = DVD_W'({req_ff.angle - lo_ff, {FRAC_W{1'b0}}});
         dvs = DVS_W'(hi_ff - lo_ff);
      end else begin
         dvd = DVD_W'({col_q_ff, 8'h00});
         dvs = DVS_W'(nh);
      end
      avg     = (|quo[DVD_W-1:INTENSITY_W]) ? {INTENSITY_W{1'b1}} : quo[INTENSITY_W-1:0];
      delta   = signed'({1'b0, a1_ff}) - signed'({1'b0, a0_ff});
      prod_in = delta * signed'({1'b0, f_ff});
      interp  = (INTENSITY_W + FRAC_W + 2)'(a0_ff) + unsigned'(prod_ff >>> FRAC_W);
   end

   ctvi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.ang_wr && req_ok) begin
         angle_mem[req_addr] <= req_data.angle;
      end
      ang_q_ff <= angle_mem[cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         col_mem[clr_ff] <= '0;
      end else if (cmd.add_wr && idx_ok) begin
         col_mem[idx_addr] <= sum_sat;
      end
      col_q_ff <= col_mem[col_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vert_ff <= '0;
         num_horz_ff <= '0;
         clr_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               CSR_NUM_VERT: num_vert_ff <= csr_data;
               CSR_NUM_HORZ: num_horz_ff <= csr_data;
            endcase
         end
         if (cmd.clr_init) begin
            clr_ff <= '0;
         end else if (cmd.clr_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.scan_init) begin
            cnt_ff <= '0;
         end else if (cmd.scan) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan) begin
         prev_ff <= ang_q_ff;
         if (hit) begin
            lo_ff  <= prev_ff;
            hi_ff  <= ang_q_ff;
            sel_ff <= AW'(cnt_ff - CW'(2));
         end
      end
      if (cmd.sel_zero) begin
         sel_ff <= '0;
      end
      if (cmd.store_a0) begin
         a0_ff <= avg;
      end
      if (cmd.store_a1) begin
         a1_ff <= avg;
      end
      if (cmd.store_f) begin
         f_ff <= quo[FRAC_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.fin) begin
         rsp_ff.intensity <= interp[INTENSITY_W-1:0];
         rsp_ff.found     <= 1'b1;
      end else if (cmd.single_res) begin
         rsp_ff.intensity <= avg;
         rsp_ff.found     <= 1'b1;
      end else if (cmd.zero_res) begin
         rsp_ff.intensity <= '0;
         rsp_ff.found     <= 1'b0;
      end
   end

   always_comb begin
      status.nv_zero  = (nv == '0);
      status.nh_zero  = (nh == '0);
      status.nv_one   = (nv == CSR_W'(1));
      status.scan_hit = hit;
      status.scan_end = (32'(cnt_ff) >= 2) && (32'(cnt_ff) == 32'(nv));
      status.div_done = div_done;
      status.clr_last = (32'(clr_ff) == MAX_VERT - 1);
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/ctvi_ctrl.sv
// Controller state machine: sequences loads, clears, scan, divides and output.
// Depends on ctvi_pkg.
module ctvi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ctvi_pkg::op_type     operation,
   input  ctvi_pkg::status_type status,
   output ctvi_pkg::cmd_type    cmd,
   output logic                 busy
);
   import ctvi_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (operation)
                  OP_WRITE_ANGLE: state_in = ST_IDLE;
                  OP_ADD_CANDELA: state_in = ST_ADD_RD;
                  OP_CLEAR_SUMS:  state_in = ST_CLEAR;
                  OP_QUERY: begin
                     priority if (status.nv_zero || status.nh_zero) state_in = ST_OUT;
                     else if (status.nv_one)                        state_in = ST_RD0;
                     else                                           state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_ADD_RD:  state_in = ST_ADD_WR;
         ST_ADD_WR:  state_in = ST_IDLE;
         ST_SCAN: begin
            priority if (status.scan_hit) state_in = ST_RD0;
            else if (status.scan_end)     state_in = ST_OUT;
         end
         ST_RD0:     state_in = ST_DIV0_GO;
         ST_DIV0_GO: state_in = ST_DIV0;
         ST_DIV0: begin
            if (status.div_done) state_in = status.nv_one ? ST_OUT : ST_RD1;
         end
         ST_RD1:     state_in = ST_DIV1_GO;
         ST_DIV1_GO: state_in = ST_DIV1;
         ST_DIV1:    if (status.div_done) state_in = ST_DIVF;
         ST_DIVF:    if (status.div_done) state_in = ST_MUL;
         ST_MUL:     state_in = ST_FIN;
         ST_FIN:     state_in = ST_OUT;
         ST_OUT:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.col_sel = COL_SEL_INDEX;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               unique case (operation)
                  OP_WRITE_ANGLE: cmd.ang_wr   = 1'b1;
                  OP_CLEAR_SUMS:  cmd.clr_init = 1'b1;
                  OP_ADD_CANDELA: cmd.clr_init = 1'b0;
                  OP_QUERY: begin
                     cmd.scan_init = 1'b1;
                     cmd.sel_zero  = 1'b1;
                     cmd.zero_res  = 1'b1;
                  end
               endcase
            end
         end
         ST_ADD_RD: cmd.col_sel = COL_SEL_INDEX;
         ST_ADD_WR: cmd.add_wr  = 1'b1;
         ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.zero_res = 1'b1;
         end
         ST_RD0:     cmd.col_sel   = COL_SEL_LOW;
         ST_DIV0_GO: cmd.div_start = 1'b1;
         ST_DIV0: begin
            cmd.store_a0   = status.div_done;
            // single-entry table: the column-0 average is the answer
            cmd.single_res = status.div_done && status.nv_one;
         end
         ST_RD1:     cmd.col_sel   = COL_SEL_HIGH;
         ST_DIV1_GO: cmd.div_start = 1'b1;
         ST_DIV1: begin
            cmd.store_a1  = status.div_done;
            cmd.div_start = status.div_done;
            cmd.div_frac  = 1'b1;
         end
         ST_DIVF: cmd.store_f = status.div_done;
         ST_MUL:  cmd.mul     = 1'b1;
         ST_FIN:  cmd.fin     = 1'b1;
         ST_OUT:  cmd.rsp_valid = 1'b1;
         default: cmd.rsp_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: sv/candela_table_vertical_interp.sv
// Vertical candela-table interpolator.
// Command channel: present req_data with start high while busy is low; the word
// is taken at that edge. Operations: write angle, add candela to a column
// sum, clear sums, query.
// A query returns one word on rsp_data, marked by rsp_valid for one cycle; the
// receiver cannot stall it. Writes, adds and clears return nothing.
// A query scans the angle memory, one angle memory read a cycle; on a hit it
// runs three divisions in the shared restoring divider, then a multiply and
// output. A single-entry table needs only one division and no scan.
// Queries with no horizontal angles or an empty table go straight to output.
// One command is in flight at a time; busy stays high until it finishes.
// Reset runs a clearing pass over the column sums with busy
// high; configuration writes are taken at any time (csr_ready is always high)
// but should be made only while idle. Angle entries are undefined until written.
module candela_table_vertical_interp #(
   parameter int MAX_VERT = 1024,
   parameter int MAX_HORZ = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ctvi_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output ctvi_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  ctvi_pkg::csr_index_type       csr_index,
   input  logic [ctvi_pkg::CSR_W-1:0]    csr_data
);
   import ctvi_pkg::*;

   cmd_type    cmd;
   status_type status;

   ctvi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   ctvi_dp #(
      .MAX_VERT (MAX_VERT),
      .MAX_HORZ (MAX_HORZ)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = cmd.rsp_valid;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for candela_table_vertical_interp.
// Depends on ctvi_pkg; predicts or is given each query result and compares it against rsp_data.
module tb_top;
   import ctvi_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam int HORZ_LIMIT  = 1024;
   localparam int QUIET_LIMIT = 20000;

   typedef enum logic {ROW_WORD, ROW_REGS} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      word;
      int           nv;
      int           nh;
      bit           typed;
      rsp_type      want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_NUM_VERT;
   logic [CSR_W-1:0] csr_data = '0;

   // predictor state
   logic [ANGLE_W-1:0] angle_tab [TABLE_DEPTH];
   logic [SUM_W-1:0]   sum_tab [TABLE_DEPTH];
   bit                 angle_known [TABLE_DEPTH];
   int unsigned        num_vert_reg;
   int unsigned        num_horz_reg;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      quiet_cycles = 0;
   int      gap_pct = 0;

   always #5 clock = ~clock;

   candela_table_vertical_interp dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic longint unsigned column_average(int idx, int unsigned nh);
      longint unsigned v;
      v = (longint'(sum_tab[idx]) << 8) / nh;
      return (v > 64'h0FFF_FFFF) ? 64'h0FFF_FFFF : v;
   endfunction

   function automatic rsp_type predict_intensity(logic [ANGLE_W-1:0] ang);
      rsp_type r;
      int unsigned nv, nh;
      longint unsigned lo, hi, a0, a1, f, v;
      r = '0;
      nv = (num_vert_reg > TABLE_DEPTH) ? TABLE_DEPTH : num_vert_reg;
      nh = (num_horz_reg > HORZ_LIMIT) ? HORZ_LIMIT : num_horz_reg;
      if (nh == 0 || nv == 0) return r;
      if (nv < 2) begin
         r.intensity = INTENSITY_W'(column_average(0, nh));
         r.found = 1'b1;
         return r;
      end
      for (int i = 0; i + 1 < nv; i++) begin
         lo = angle_tab[i];
         hi = angle_tab[i+1];
         if (ang >= lo && ang < hi) begin
            a0 = column_average(i, nh);
            a1 = column_average(i + 1, nh);
            f = ((ang - lo) << 16) / (hi - lo);
            v = (a0 * (65536 - f) + a1 * f) >> 16;
            r.intensity = (v > 64'h0FFF_FFFF) ? 28'hFFF_FFFF : v[27:0];
            r.found = 1'b1;
            return r;
         end
      end
      return r;
   endfunction

   function automatic req_type mk(op_type op, int idx, int ang, int cd);
      req_type w;
      w.operation = op;
      w.index = INDEX_W'(idx);
      w.angle = ANGLE_W'(ang);
      w.candela = CANDELA_W'(cd);
      return w;
   endfunction

   // update the model for a taken word; queries queue their answer
   task automatic apply_word(input req_type w, input bit typed, input rsp_type want);
      longint unsigned s;
      case (w.operation)
         OP_WRITE_ANGLE: begin
            angle_tab[w.index] = w.angle;
            angle_known[w.index] = 1'b1;
         end
         OP_ADD_CANDELA: begin
            s = longint'(sum_tab[w.index]) + w.candela;
            sum_tab[w.index] = (s > 64'h3FFF_FFFF) ? 30'h3FFF_FFFF : s[29:0];
         end
         OP_CLEAR_SUMS: begin
            foreach (sum_tab[i]) sum_tab[i] = '0;
         end
         default: begin
            pending_rsp.push_back(typed ? want : predict_intensity(w.angle));
         end
      endcase
   endtask

   // start stays high across back-to-back words; only a gap or a drain lowers it
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      req_data <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      apply_word(w, typed, want);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send(input req_type w);
      send_word(w, 1'b0, '0);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input int nv, input int nh);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_NUM_VERT;
      csr_data <= CSR_W'(nv);
      do @(posedge clock); while (!csr_ready);
      num_vert_reg = nv;
      csr_index <= CSR_NUM_HORZ;
      csr_data <= CSR_W'(nh);
      do @(posedge clock); while (!csr_ready);
      num_horz_reg = nh;
      csr_valid <= 1'b0;
   endtask

   // fill unwritten angle entries below n with a rising sequence
   task automatic fill_angles(input int n);
      int a;
      a = 0;
      for (int i = 0; i < n && i < TABLE_DEPTH; i++) begin
         if (angle_known[i]) a = angle_tab[i];
         else begin
            a = a + $urandom_range(1, 12);
            if (a > 16383) a = 16383;
            send(mk(OP_WRITE_ANGLE, i, a, 0));
         end
      end
   endtask

   function automatic req_type random_word(int nv);
      int roll, nvc, i, lo, hi;
      req_type w;
      nvc = (nv > TABLE_DEPTH) ? TABLE_DEPTH : nv;
      roll = $urandom_range(99);
      w = mk(OP_QUERY, $urandom_range(1023), $urandom_range(16383), $urandom_range(20'hFFFFF));
      if (roll < 3) w.operation = OP_CLEAR_SUMS;
      else if (roll < 30) begin
         w.operation = OP_WRITE_ANGLE;
         if (nvc > 0 && $urandom_range(3) != 0) w.index = INDEX_W'($urandom_range(nvc - 1));
      end else if (roll < 62) begin
         w.operation = OP_ADD_CANDELA;
         if (nvc > 0 && $urandom_range(3) != 0) w.index = INDEX_W'($urandom_range(nvc - 1));
         if ($urandom_range(3) == 0) w.candela = 20'hFFFFF;
      end else if (nvc >= 2 && $urandom_range(3) != 0) begin
         // aim inside a stored interval when it is ordered
         i = $urandom_range(nvc - 2);
         lo = angle_tab[i];
         hi = angle_tab[i+1];
         if (lo < hi) w.angle = ANGLE_W'($urandom_range(hi - 1, lo));
         else w.angle = ANGLE_W'(lo);
      end
      return w;
   endfunction

   stim_row_type rows [$];

   task automatic add_row(row_kind_type k, req_type w, int nv, int nh, bit typed, rsp_type want);
      stim_row_type r;
      r.kind = k; r.word = w; r.nv = nv; r.nh = nh; r.typed = typed; r.want = want;
      rows.push_back(r);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) report("result word with nothing expected");
         else begin
            want = pending_rsp.pop_front();
            if (rsp_data.intensity !== want.intensity)
               report($sformatf("intensity %0h, expected %0h", rsp_data.intensity,
                                want.intensity));
            if (rsp_data.found !== want.found)
               report($sformatf("found %0b, expected %0b", rsp_data.found, want.found));
         end
      end
   end

   // watchdog: cycles with neither a taken word nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   int phase_nv [8] = '{2, 8, 16, 32, 96, 96, 5, 3};
   int phase_nh [8] = '{1, 3, 1024, 2047, 7, 1, 0, 1};
   int phase_gap [8] = '{0, 59, 0, 10, 0, 59, 10, 0};
   int phase_len [8] = '{70, 70, 70, 70, 40, 40, 30, 40};

   initial begin
      rsp_type none, full;
      none = '0;
      full.intensity = 28'hFFFFF00;
      full.found = 1'b1;
      foreach (angle_tab[i]) begin
         angle_tab[i] = '0;
         sum_tab[i] = '0;
         angle_known[i] = 1'b0;
      end
      num_vert_reg = 0;
      num_horz_reg = 0;

      add_row(ROW_WORD, mk(OP_QUERY, 0, 0, 0), 0, 0, 1, none);
      add_row(ROW_REGS, '0, 1, 1, 0, none);
      add_row(ROW_WORD, mk(OP_ADD_CANDELA, 0, 0, 20'hFFFFF), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 5, 0), 0, 0, 1, full);
      add_row(ROW_REGS, '0, 1, 0, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 5, 0), 0, 0, 1, none);
      add_row(ROW_WORD, mk(OP_CLEAR_SUMS, 0, 0, 0), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_WRITE_ANGLE, 0, 0, 0), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_WRITE_ANGLE, 1, 11520, 0), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_WRITE_ANGLE, 2, 16383, 0), 0, 0, 0, none);
      add_row(ROW_REGS, '0, 2, 2, 0, none);
      add_row(ROW_WORD, mk(OP_ADD_CANDELA, 1, 0, 1000), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_ADD_CANDELA, 0, 0, 20'hFFFFF), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 0, 0), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 5760, 0), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 11520, 0), 0, 0, 1, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 16383, 0), 0, 0, 1, none);
      add_row(ROW_REGS, '0, 3, 1, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 1023, 16383, 0), 0, 0, 1, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 16382, 0), 0, 0, 0, none);
      add_row(ROW_WORD, mk(OP_QUERY, 0, 11520, 0), 0, 0, 0, none);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[k]) begin
         if (rows[k].kind == ROW_REGS) write_regs(rows[k].nv, rows[k].nh);
         else send_word(rows[k].word, rows[k].typed, rows[k].want);
      end

      // push the column-0 average past full scale, then read it back through one entry
      for (int k = 0; k < 2; k++) send(mk(OP_ADD_CANDELA, 0, 0, 20'hFFFFF));
      write_regs(1, 1);
      send(mk(OP_QUERY, 0, 0, 0));
      send(mk(OP_CLEAR_SUMS, 0, 0, 0));

      for (int p = 0; p < 8; p++) begin
         write_regs(phase_nv[p], phase_nh[p]);
         gap_pct = phase_gap[p];
         fill_angles(phase_nv[p]);
         for (int k = 0; k < phase_len[p]; k++) begin
            // hold off until the block has answered everything
            if (p == 1 && k == phase_len[p] / 2) drain();
            send(random_word(phase_nv[p]));
         end
      end

      start <= 1'b0;
      for (int w = 0; w < 50000 && (pending_rsp.size() != 0 || busy); w++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) $display("status: pass");
      else begin
         if (pending_rsp.size() != 0) report("expected result words never arrived");
         $display("status: fail");
      end
      $finish;
   end

endmodule
